>>> design/tce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tour cost evaluator package
// Shared constants, payload structs, action codes and controller states.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int MAX_CITIES = 64;
  localparam int DIST_BITS  = 16;

  localparam int CITY_W     = 6;
  localparam int POS_W      = 6;
  localparam int DIST_IN_W  = 16;
  localparam int CFG_W      = 7;
  localparam int COST_W     = 23;
  localparam int OUT_COST_W = 22;

  localparam int TOUR_AW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int CNT_W   = $clog2(MAX_CITIES + 1);
  localparam int DIST_AW = $clog2(MAX_CITIES * MAX_CITIES);

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_SET  = 2'd1,
    ACT_FIND = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COST,
    ST_FIND,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]           action;
    logic [CITY_W-1:0]    from_city;
    logic [CITY_W-1:0]    to_city;
    logic [DIST_IN_W-1:0] distance;
    logic [POS_W-1:0]     tour_position;
    logic [CITY_W-1:0]    city;
  } in_item_t;

  typedef struct packed {
    logic [OUT_COST_W-1:0] tour_cost;
    logic                  found;
    logic [POS_W-1:0]      found_position;
  } out_result_t;

endpackage

>>> design/tce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/tour_cost_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tour cost evaluator
// Holds a distance matrix and a closed tour and keeps the tour length.
// ----------------------------------------------------------------------------
// Usage: every input transfer carries one action. A load writes one entry of
// the distance matrix, a set places a city at one tour position and then
// recomputes the closed-tour cost, and a find looks up the first position
// holding a city. Every input transfer yields exactly one output transfer,
// which carries the stored cost and, for a find, the search outcome.
// The configuration channel writes city_count; it is always ready. It must be
// written only while the block is idle; the block itself does not enforce it.
// A load and the unused action go straight to the done state. A set walks the
// tour for the closed-tour cost and a find walks it for the search: the tour
// memory read port delivers one tour position per cycle, the cost walk reads
// one extra position to close the loop back to position 0, and a link's
// distance read and add follow the last tour read in the distance read stage.
// One item is processed at a time; the next input transfer is taken as soon
// as the result is parked in the output register, even if the receiver has
// not taken it yet. If the receiver stalls with a result still parked, a
// finished item waits in its done state until the output register frees.
// Reset clears the tour (through per-position valid bits, no clearing pass),
// the cost and the city count (back to the maximum). Matrix entries are
// undefined until loaded.
// ----------------------------------------------------------------------------
module tour_cost_evaluator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tce_pkg::CFG_W-1:0] cfg_city_count_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  tce_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tce_pkg::out_result_t      out_result_o
);

  // Controller state.
  tce_pkg::state_e state_q, state_d;

  // Clamped number of cities in use.
  logic [tce_pkg::CNT_W-1:0] n_q;

  // Memory ports.
  logic                          dist_we;
  logic [tce_pkg::DIST_AW-1:0]   dist_waddr;
  logic [tce_pkg::DIST_AW-1:0]   dist_raddr;
  logic [tce_pkg::DIST_BITS-1:0] dist_rdata;
  logic                          tour_we;
  logic [tce_pkg::TOUR_AW-1:0]   tour_waddr;
  logic [tce_pkg::TOUR_AW-1:0]   tour_raddr;
  logic [tce_pkg::CITY_W-1:0]    tour_rdata;

  // Tour positions written since reset; unwritten ones read as city zero.
  logic [tce_pkg::MAX_CITIES-1:0] tour_vld_q;
  logic                           tour_rvld_q;
  logic [tce_pkg::CITY_W-1:0]     tour_city;

  // Position walk: issue stage, tour read stage, distance read stage.
  logic [tce_pkg::CNT_W-1:0]  iss_cnt_q;
  logic                       iss_done_q;
  logic [tce_pkg::CNT_W-1:0]  iss_end;
  logic                       issuing;
  logic                       s1_vld_q;
  logic [tce_pkg::CNT_W-1:0]  s1_idx_q;
  logic [tce_pkg::CITY_W-1:0] prev_q;
  logic                       link_vld;
  logic                       s2_vld_q;
  logic                       s2_zero_q;
  logic                       run_done;

  // Cost and search results.
  logic [tce_pkg::COST_W-1:0] sum_q;
  logic [tce_pkg::COST_W-1:0] cost_q;
  logic [tce_pkg::CITY_W-1:0] search_q;
  logic                       found_q;
  logic [tce_pkg::POS_W-1:0]  found_pos_q;

  // Output register.
  logic                 out_valid_q;
  logic                 out_load;
  tce_pkg::out_result_t out_q;

  logic in_acc;

  // The configuration register is always writable.
  assign cfg_ready_o = 1'b1;

  // Input transfers are taken only while no item is in flight.
  assign in_ready_o = (state_q == tce_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // A city count of zero acts as one; anything above the matrix size is capped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= tce_pkg::CNT_W'(tce_pkg::MAX_CITIES);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_city_count_i == '0) begin
        n_q <= tce_pkg::CNT_W'(1);
      end else if (32'(cfg_city_count_i) > 32'(tce_pkg::MAX_CITIES)) begin
        n_q <= tce_pkg::CNT_W'(tce_pkg::MAX_CITIES);
      end else begin
        n_q <= tce_pkg::CNT_W'(cfg_city_count_i);
      end
    end
  end

  // Loads write the matrix directly at the input transfer; out-of-range rows
  // and columns are dropped.
  assign dist_we = in_acc && (in_item_i.action == tce_pkg::ACT_LOAD) &&
                   (32'(in_item_i.from_city) < 32'(tce_pkg::MAX_CITIES)) &&
                   (32'(in_item_i.to_city) < 32'(tce_pkg::MAX_CITIES));
  assign dist_waddr = tce_pkg::DIST_AW'(in_item_i.from_city) *
                      tce_pkg::DIST_AW'(tce_pkg::MAX_CITIES) +
                      tce_pkg::DIST_AW'(in_item_i.to_city);

  // A set writes the tour at the input transfer, so the cost walk that starts
  // on the next cycle already reads the new city.
  assign tour_we = in_acc && (in_item_i.action == tce_pkg::ACT_SET) &&
                   (32'(in_item_i.tour_position) < 32'(n_q));
  assign tour_waddr = tce_pkg::TOUR_AW'(in_item_i.tour_position);

  tce_ram #(
    .WIDTH(tce_pkg::DIST_BITS),
    .DEPTH(tce_pkg::MAX_CITIES * tce_pkg::MAX_CITIES)
  ) u_dist_ram (
    .clk_i  (clk_i),
    .we_i   (dist_we),
    .waddr_i(dist_waddr),
    .wdata_i(tce_pkg::DIST_BITS'(in_item_i.distance)),
    .raddr_i(dist_raddr),
    .rdata_o(dist_rdata)
  );

  tce_ram #(
    .WIDTH(tce_pkg::CITY_W),
    .DEPTH(tce_pkg::MAX_CITIES)
  ) u_tour_ram (
    .clk_i  (clk_i),
    .we_i   (tour_we),
    .waddr_i(tour_waddr),
    .wdata_i(in_item_i.city),
    .raddr_i(tour_raddr),
    .rdata_o(tour_rdata)
  );

  // The cost walk reads positions 0 .. n, where the final read wraps back to
  // position 0 to close the tour. A find reads positions 0 .. n-1 only.
  assign iss_end = (state_q == tce_pkg::ST_COST) ? n_q : n_q - tce_pkg::CNT_W'(1);
  assign issuing = ((state_q == tce_pkg::ST_COST) || (state_q == tce_pkg::ST_FIND)) &&
                   !iss_done_q;
  assign tour_raddr = (iss_cnt_q == n_q) ? '0 : tce_pkg::TOUR_AW'(iss_cnt_q);
  assign tour_city  = tour_rvld_q ? tour_rdata : '0;

  // Each tour read after the first forms one link with the city before it.
  assign link_vld   = s1_vld_q && (state_q == tce_pkg::ST_COST) && (s1_idx_q != '0);
  assign dist_raddr = tce_pkg::DIST_AW'(prev_q) * tce_pkg::DIST_AW'(tce_pkg::MAX_CITIES) +
                      tce_pkg::DIST_AW'(tour_city);

  assign run_done = iss_done_q && !s1_vld_q && !s2_vld_q;

  // Control flops of the walk and the tour valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tour_vld_q <= '0;
      iss_done_q <= 1'b1;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      cost_q     <= '0;
      found_q    <= 1'b0;
    end else begin
      if (tour_we) begin
        tour_vld_q[tour_waddr] <= 1'b1;
      end
      if (in_acc) begin
        iss_done_q <= !((in_item_i.action == tce_pkg::ACT_SET) ||
                        (in_item_i.action == tce_pkg::ACT_FIND));
        found_q    <= 1'b0;
      end else if (issuing && (iss_cnt_q == iss_end)) begin
        iss_done_q <= 1'b1;
      end
      s1_vld_q <= issuing;
      s2_vld_q <= link_vld;
      if ((state_q == tce_pkg::ST_FIND) && s1_vld_q && !found_q && (tour_city == search_q)) begin
        found_q <= 1'b1;
      end
      if ((state_q == tce_pkg::ST_COST) && run_done) begin
        cost_q <= sum_q;
      end
    end
  end

  // Walk datapath.
  always_ff @(posedge clk_i) begin
    tour_rvld_q <= tour_vld_q[tour_raddr];
    s1_idx_q    <= iss_cnt_q;
    if (in_acc) begin
      iss_cnt_q   <= '0;
      sum_q       <= '0;
      found_pos_q <= '0;
      search_q    <= in_item_i.city;
    end else begin
      if (issuing) begin
        iss_cnt_q <= iss_cnt_q + tce_pkg::CNT_W'(1);
      end
      if (s2_vld_q && !s2_zero_q) begin
        sum_q <= sum_q + tce_pkg::COST_W'(dist_rdata);
      end
      if ((state_q == tce_pkg::ST_FIND) && s1_vld_q && !found_q && (tour_city == search_q)) begin
        found_pos_q <= tce_pkg::POS_W'(s1_idx_q);
      end
    end
    if (s1_vld_q) begin
      prev_q <= tour_city;
    end
    // A city outside the matrix contributes a zero link.
    s2_zero_q <= (32'(prev_q) >= 32'(tce_pkg::MAX_CITIES)) ||
                 (32'(tour_city) >= 32'(tce_pkg::MAX_CITIES));
  end

  // Output register: a finished result is parked here until taken.
  assign out_load = (state_q == tce_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.tour_cost      <= cost_q[tce_pkg::OUT_COST_W-1:0];
      out_q.found          <= found_q;
      out_q.found_position <= found_pos_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  // Controller.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tce_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tce_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_item_i.action)
            tce_pkg::ACT_SET:  state_d = tce_pkg::ST_COST;
            tce_pkg::ACT_FIND: state_d = tce_pkg::ST_FIND;
            default:           state_d = tce_pkg::ST_DONE;
          endcase
        end
      end
      tce_pkg::ST_COST, tce_pkg::ST_FIND: begin
        if (run_done) begin
          state_d = tce_pkg::ST_DONE;
        end
      end
      tce_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = tce_pkg::ST_IDLE;
        end
      end
      default: state_d = tce_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> tb/sv/tb_tour_cost_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tour cost evaluator testbench
// Drives load, set, find and unused-code transfers with random gaps and output
// stalls. A local model of the matrix, tour, cost and city count predicts each result.
// Every output transfer is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_tour_cost_evaluator_unit;
  import tce_pkg::*;

  // The action code that the block must treat as a no-op.
  localparam logic [1:0] ACT_UNUSED    = 2'd3;
  localparam int         DIST_ENTRIES  = MAX_CITIES * MAX_CITIES;
  // The settle time is kept well above the time a set takes with the largest city count.
  localparam int         SETTLE_CYCLES = 2 * MAX_CITIES + 16;
  localparam int         CYCLE_LIMIT   = 1_500_000;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_city_count_i;
  logic             in_valid_i;
  logic             in_ready_o;
  in_item_t         in_item_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_result_t      out_result_o;

  tour_cost_evaluator_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_city_count_i (cfg_city_count_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_item_i        (in_item_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_result_o     (out_result_o)
  );

  // Local copy of everything the block holds. The loaded flags keep the
  // stimulus from ever summing a matrix entry that was never written.
  logic [DIST_BITS-1:0] dist_mem    [DIST_ENTRIES];
  bit                   dist_loaded [DIST_ENTRIES];
  logic [CITY_W-1:0]    tour_mem    [MAX_CITIES];
  logic [COST_W-1:0]    tour_length;
  logic [CFG_W-1:0]     city_count_reg;

  // Results predicted for accepted items, oldest first.
  out_result_t pending_reports [$];
  out_result_t head_report;

  int unsigned failures;
  int unsigned cycle_count;
  int unsigned cfg_writes;
  int unsigned burst_left;
  int unsigned ready_hold;
  int unsigned ready_roll;
  int unsigned action_tally [4];

  // Clock: 8 ns period, starting low.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count++;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // A count of zero acts as one, and anything above the matrix size acts as
  // the matrix size.
  function automatic int cities_active();
    if (city_count_reg == '0) return 1;
    if (city_count_reg > MAX_CITIES) return MAX_CITIES;
    return int'(city_count_reg);
  endfunction

  // Sum of every link of the tour in use, the last position linking back to
  // position zero, wrapping in the width of the stored cost.
  function automatic logic [COST_W-1:0] closed_tour_length();
    int                n;
    logic [COST_W-1:0] sum;
    n   = cities_active();
    sum = '0;
    for (int i = 0; i < n; i++) begin
      sum = sum + dist_mem[{tour_mem[i], tour_mem[(i + 1) % n]}];
    end
    return sum;
  endfunction

  // Applies one accepted item to the local state and returns its result.
  function automatic out_result_t evaluate_item(in_item_t it);
    out_result_t res;
    int          n;
    res = '0;
    n   = cities_active();
    case (it.action)
      ACT_LOAD: begin
        dist_mem[{it.from_city, it.to_city}]    = it.distance[DIST_BITS-1:0];
        dist_loaded[{it.from_city, it.to_city}] = 1'b1;
      end
      ACT_SET: begin
        // A position outside the tour in use writes nothing, but the cost
        // is still recomputed.
        if (it.tour_position < n) tour_mem[it.tour_position] = it.city;
        tour_length = closed_tour_length();
      end
      ACT_FIND: begin
        // Scanning downward leaves the first matching position in place.
        for (int i = n - 1; i >= 0; i--) begin
          if (tour_mem[i] == it.city) begin
            res.found          = 1'b1;
            res.found_position = POS_W'(i);
          end
        end
      end
      default: begin
      end
    endcase
    res.tour_cost = tour_length[OUT_COST_W-1:0];
    return res;
  endfunction

  // Number of input transfers made so far.
  function automatic int unsigned items_sent();
    return action_tally[0] + action_tally[1] + action_tally[2] + action_tally[3];
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every output transfer is matched against the oldest
  // expectation. A result with nothing outstanding is a failure on its own.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $error("result with no item outstanding: tour_cost %0d found %0d",
               out_result_o.tour_cost, out_result_o.found);
        failures++;
      end else begin
        head_report = pending_reports.pop_front();
        if (out_result_o.tour_cost !== head_report.tour_cost) begin
          $error("tour_cost mismatch: expected %0d, actual %0d",
                 head_report.tour_cost, out_result_o.tour_cost);
          failures++;
        end
        if (out_result_o.found !== head_report.found) begin
          $error("found mismatch: expected %0d, actual %0d",
                 head_report.found, out_result_o.found);
          failures++;
        end
        if (out_result_o.found_position !== head_report.found_position) begin
          $error("found_position mismatch: expected %0d, actual %0d",
                 head_report.found_position, out_result_o.found_position);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready changes at the falling edge. Mostly short runs of ready
  // and short stalls, some long stalls, and now and then a long stretch with
  // no stall at all.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i = 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 55) begin
        out_ready_i = 1'b1;
        ready_hold  = $urandom_range(0, 7);
      end else if (ready_roll < 80) begin
        out_ready_i = 1'b0;
        ready_hold  = $urandom_range(0, 2);
      end else if (ready_roll < 92) begin
        out_ready_i = 1'b0;
        ready_hold  = $urandom_range(10, 40);
      end else begin
        out_ready_i = 1'b1;
        ready_hold  = $urandom_range(100, 300);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Idle cycles before the next input transfer. Bursts with no gap at all
  // alternate with mostly short and a few long gaps.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [DIST_IN_W-1:0] random_distance();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return DIST_IN_W'($urandom_range(0, 65535));
    if (r < 8) return DIST_IN_W'($urandom_range(0, 255));
    if (r == 8) return '1;
    return '0;
  endfunction

  // Half the cities come from a small pool so that loads and searches keep
  // hitting what the tour holds.
  function automatic logic [CITY_W-1:0] pick_city();
    if ($urandom_range(0, 1) == 0) return CITY_W'($urandom_range(0, 7));
    return CITY_W'($urandom_range(0, MAX_CITIES - 1));
  endfunction

  // Fields that an action does not use still carry random values.
  function automatic in_item_t random_item(logic [1:0] action);
    in_item_t it;
    it.action        = action;
    it.from_city     = CITY_W'($urandom_range(0, 63));
    it.to_city       = CITY_W'($urandom_range(0, 63));
    it.distance      = DIST_IN_W'($urandom_range(0, 65535));
    it.tour_position = POS_W'($urandom_range(0, 63));
    it.city          = CITY_W'($urandom_range(0, 63));
    return it;
  endfunction

  // Sends one item and waits for its transfer. Starts and ends at a falling
  // edge; valid is left low so nothing is taken twice. Blocking assignments
  // at the falling edge keep the drive clear of the sampling edge.
  task automatic send_item(in_item_t it);
    int          gap;
    out_result_t expected;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected        = evaluate_item(it);
    pending_reports = {pending_reports, expected};
    action_tally[it.action]++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic load_entry(logic [CITY_W-1:0] from_city, logic [CITY_W-1:0] to_city,
                            logic [DIST_IN_W-1:0] distance);
    in_item_t it;
    it           = random_item(ACT_LOAD);
    it.from_city = from_city;
    it.to_city   = to_city;
    it.distance  = distance;
    send_item(it);
  endtask

  task automatic find_city(logic [CITY_W-1:0] city);
    in_item_t it;
    it      = random_item(ACT_FIND);
    it.city = city;
    send_item(it);
  endtask

  // Places a city in the tour. Any link of the new tour whose matrix entry
  // was never loaded gets a load first, so the recomputed sum only reads
  // written entries.
  task automatic place_city(logic [POS_W-1:0] pos, logic [CITY_W-1:0] city);
    logic [CITY_W-1:0] next_tour [MAX_CITIES];
    int                n;
    int                k;
    in_item_t          it;
    n         = cities_active();
    next_tour = tour_mem;
    if (pos < n) next_tour[pos] = city;
    for (int i = 0; i < n; i++) begin
      k = (i + 1) % n;
      if (!dist_loaded[{next_tour[i], next_tour[k]}]) begin
        load_entry(next_tour[i], next_tour[k], random_distance());
      end
    end
    it               = random_item(ACT_SET);
    it.tour_position = pos;
    it.city          = city;
    send_item(it);
  endtask

  // Holds the sender back until every predicted result has come out.
  task automatic wait_reports_drained();
    in_valid_i = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
  endtask

  // The city count is only written with the block idle: nothing outstanding
  // and a few spare cycles for it to settle.
  task automatic write_city_count(logic [CFG_W-1:0] value);
    wait_reports_drained();
    repeat (8) @(negedge clk_i);
    cfg_city_count_i = value;
    cfg_valid_i      = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    city_count_reg = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the tour holds city zero everywhere and the cost is
  // zero: a search finds city zero at position zero and misses city 63. The
  // unused action code must answer with the cost and no search outcome.
  task automatic test_reset_tour();
    find_city('0);
    find_city(6'd63);
    send_item(random_item(ACT_UNUSED));
  endtask

  // Largest cost: a tour of 64 copies of city zero with the largest distance
  // on its self link. Then the last position, extreme loads, and a load that
  // must not move the cost until the next set.
  task automatic test_cost_extremes();
    load_entry('0, '0, '1);
    place_city(6'd17, '0);
    place_city(6'd63, 6'd63);
    find_city(6'd63);
    load_entry(6'd63, 6'd63, '1);
    load_entry('0, '0, '0);
    find_city('0);
    place_city('0, '0);
  endtask

  // City counts at and beyond the limits. A count of zero works on a single
  // position, so a search misses a city that sits beyond it and a set beyond
  // it writes nothing. A count write alone leaves the cost as it was.
  task automatic test_count_limits();
    write_city_count('0);
    find_city(6'd63);
    place_city(6'd1, 6'd7);
    place_city('0, 6'd42);
    write_city_count(7'd127);
    find_city(6'd42);
    place_city(6'd63, 6'd21);
    write_city_count(7'd1);
    place_city('0, 6'd63);
    write_city_count(7'd64);
    find_city(6'd21);
  endtask

  // Random mix under one city count: loads, sets (some beyond the tour in
  // use), searches mostly for cities the tour holds, and a few unused codes.
  // The item count includes the loads that a set brings along.
  task automatic test_random_traffic(logic [CFG_W-1:0] count_value, int items);
    int                n;
    int                r;
    int unsigned       first;
    logic [POS_W-1:0]  pos;
    logic [CITY_W-1:0] city;
    write_city_count(count_value);
    first = items_sent();
    while (int'(items_sent() - first) < items) begin
      n    = cities_active();
      r    = $urandom_range(0, 99);
      city = pick_city();
      if (r < 25) begin
        load_entry(pick_city(), pick_city(), random_distance());
      end else if (r < 65) begin
        if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(0, MAX_CITIES - 1));
        else pos = POS_W'($urandom_range(0, n - 1));
        place_city(pos, city);
      end else if (r < 95) begin
        if ($urandom_range(0, 2) != 0) city = tour_mem[$urandom_range(0, n - 1)];
        find_city(city);
      end else begin
        send_item(random_item(ACT_UNUSED));
      end
      // Now and then let the pipeline run completely dry.
      if ($urandom_range(0, 149) == 0) wait_reports_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    in_item_i        = '0;
    cfg_valid_i      = 1'b0;
    cfg_city_count_i = '0;
    for (int i = 0; i < DIST_ENTRIES; i++) begin
      dist_mem[i]    = '0;
      dist_loaded[i] = 1'b0;
    end
    for (int i = 0; i < MAX_CITIES; i++) begin
      tour_mem[i] = '0;
    end
    tour_length    = '0;
    city_count_reg = 7'd64;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_tour();
    test_cost_extremes();
    test_count_limits();
    test_random_traffic(7'd64, 500);
    test_random_traffic(7'($urandom_range(2, 63)), 300);
    test_random_traffic('0, 100);
    test_random_traffic(7'd127, 250);
    test_random_traffic(7'd3, 200);
    test_random_traffic(7'($urandom_range(65, 126)), 150);
    test_random_traffic(7'($urandom_range(1, 64)), 250);

    wait_reports_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Run covered %0d loads, %0d tour sets, %0d searches, %0d unused codes.",
             action_tally[ACT_LOAD], action_tally[ACT_SET], action_tally[ACT_FIND],
             action_tally[ACT_UNUSED]);
    $display("City count written %0d times (0, 1, 3, 64, above 64, random); %0d mismatches.",
             cfg_writes, failures);
    if (failures == 0 && pending_reports.size() == 0) begin
      $display("[tour_cost_evaluator_unit] OK");
    end else begin
      $display("[tour_cost_evaluator_unit] ERROR");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Cycle limit of %0d reached with %0d results outstanding.",
             CYCLE_LIMIT, pending_reports.size());
    $display("[tour_cost_evaluator_unit] ERROR");
    $finish;
  end

endmodule
